>>> design/xed_pkg.sv
// ----------------------------------------------------------------------------
// xed_pkg
// Shared types, character codes and helper functions for the entity decoder.
// ----------------------------------------------------------------------------
package xed_pkg;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_X_LO = 8'h78;
   localparam logic [7:0] CH_X_UP = 8'h58;

   localparam logic [20:0] CODE_MAX = 21'h10FFFF;
   localparam logic [20:0] CODE_SAT = 21'h110000;

   localparam int NUM_NAMES = 5;

   // queue word between front and back
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_amp;
      logic       is_semi;
   } word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAKE,
      ST_FIN,
      ST_UTF,
      ST_RAW,
      ST_RESCAN,
      ST_FLUSH,
      ST_END
   } state_type;

   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] bytes;
   } utf_type;

   // named entity bodies: amp, lt, gt, quot, apos (byte 0 in the low bits)
   function automatic logic [31:0] name_word(input logic [2:0] k);
      logic [31:0] w;
      case (k)
         3'd0:    w = 32'h00706D61;
         3'd1:    w = 32'h0000746C;
         3'd2:    w = 32'h00007467;
         3'd3:    w = 32'h746F7571;
         3'd4:    w = 32'h736F7061;
         default: w = 32'h0;
      endcase
      return w;
   endfunction

   function automatic logic [2:0] name_len(input logic [2:0] k);
      logic [2:0] n;
      case (k)
         3'd0:    n = 3'd3;
         3'd1:    n = 3'd2;
         3'd2:    n = 3'd2;
         3'd3:    n = 3'd4;
         3'd4:    n = 3'd4;
         default: n = 3'd7;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] name_out(input logic [2:0] k);
      logic [7:0] c;
      case (k)
         3'd0:    c = 8'h26;
         3'd1:    c = 8'h3C;
         3'd2:    c = 8'h3E;
         3'd3:    c = 8'h22;
         3'd4:    c = 8'h27;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // {valid, value}
   function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (hex && c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (hex && c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // one digit step with saturation above the code range
   function automatic logic [20:0] acc_step(input logic [20:0] v, input logic [3:0] d,
                                            input logic hex);
      logic [24:0] t;
      if (hex) begin
         t = {v, 4'b0};
      end else begin
         t = {1'b0, v, 3'b0} + {3'b0, v, 1'b0};
      end
      t = t + {21'b0, d};
      if (t > {4'b0, CODE_MAX}) begin
         return CODE_SAT;
      end
      return t[20:0];
   endfunction

   function automatic utf_type utf8_enc(input logic [20:0] v);
      utf_type u;
      u.bytes = '0;
      if (v < 21'h80) begin
         u.count    = 3'd1;
         u.bytes[0] = v[7:0];
      end else if (v < 21'h800) begin
         u.count    = 3'd2;
         u.bytes[0] = {3'b110, v[10:6]};
         u.bytes[1] = {2'b10, v[5:0]};
      end else if (v < 21'h10000) begin
         u.count    = 3'd3;
         u.bytes[0] = {4'b1110, v[15:12]};
         u.bytes[1] = {2'b10, v[11:6]};
         u.bytes[2] = {2'b10, v[5:0]};
      end else begin
         u.count    = 3'd4;
         u.bytes[0] = {5'b11110, v[20:18]};
         u.bytes[1] = {2'b10, v[17:12]};
         u.bytes[2] = {2'b10, v[11:6]};
         u.bytes[3] = {2'b10, v[5:0]};
      end
      return u;
   endfunction

endpackage

>>> design/xed_front.sv
// ----------------------------------------------------------------------------
// xed_front
// Input side: takes words, tags ampersand and semicolon, two-entry queue.
// ----------------------------------------------------------------------------
module xed_front import xed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       q_valid,
   output word_type   q_word,
   input  logic       q_pop
);

   word_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   word_type   tagged_word;

   assign req_ready = (fill_ff != 2'd2);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_word    = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;

   always_comb begin
      tagged_word.data    = req_in_byte;
      tagged_word.last    = req_in_last;
      tagged_word.is_amp  = (req_in_byte == CH_AMP);
      tagged_word.is_semi = (req_in_byte == CH_SEMI);
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= tagged_word;
      end
   end

endmodule

>>> design/xed_back.sv
// ----------------------------------------------------------------------------
// xed_back
// Sequencer: holds reference bytes, decodes entities, rescans, emits bytes.
// ----------------------------------------------------------------------------
module xed_back import xed_pkg::*; #(
   parameter int MAX_SPAN = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  word_type   q_word,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_message_end
);

   localparam int CW = $clog2(MAX_SPAN);

   state_type              state_ff, state_in;
   word_type               cur_ff, cur_in;
   logic                   in_ref_ff, in_ref_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [7:0]             held_ff [MAX_SPAN];
   logic [CW-1:0]          rd_ff, rd_in;
   logic [CW-1:0]          raw_len_ff, raw_len_in;
   logic                   semi_ff, semi_in;
   logic [NUM_NAMES-1:0]   match_ff, match_in;
   logic                   hash_ff, hash_in;
   logic                   isx_ff, isx_in;
   logic                   dec_ok_ff, dec_ok_in;
   logic [20:0]            dec_val_ff, dec_val_in;
   logic                   hex_ok_ff, hex_ok_in;
   logic [20:0]            hex_val_ff, hex_val_in;
   utf_type                utf_ff, utf_in;
   logic [1:0]             uidx_ff, uidx_in;
   logic                   stg_valid_ff, stg_valid_in;
   logic [7:0]             stg_byte_ff, stg_byte_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_bv_ff, rsp_bv_in;
   logic                   rsp_rl_ff, rsp_rl_in;
   logic                   rsp_me_ff, rsp_me_in;

   logic                   out_free, can_push;
   logic                   push, hold, open_ref, held_we, done;
   logic [7:0]             push_byte, hold_byte, rd_byte;
   logic [4:0]             dg_dec, dg_hex;
   logic                   named_hit, num_hex, num_ok;
   logic [7:0]             named_char;
   logic [20:0]            num_val;
   logic [31:0]            nm_word;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_byte_valid  = rsp_bv_ff;
   assign rsp_run_last    = rsp_rl_ff;
   assign rsp_message_end = rsp_me_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign can_push = !stg_valid_ff || out_free;
   assign rd_byte  = held_ff[rd_ff];

   // reference body decode
   always_comb begin
      named_hit  = 1'b0;
      named_char = 8'h00;
      for (int k = 0; k < NUM_NAMES; k++) begin
         if (match_ff[k] && count_ff == CW'(name_len(3'(k)))) begin
            named_hit  = 1'b1;
            named_char = name_out(3'(k));
         end
      end
      num_hex = (count_ff > CW'(2)) && isx_ff;
      num_val = num_hex ? hex_val_ff : dec_val_ff;
      num_ok  = (count_ff > CW'(1)) && hash_ff && (num_hex ? hex_ok_ff : dec_ok_ff) &&
                (num_val != 21'd0) && (num_val <= CODE_MAX);
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      in_ref_in  = in_ref_ff;
      count_in   = count_ff;
      rd_in      = rd_ff;
      raw_len_in = raw_len_ff;
      semi_in    = semi_ff;
      utf_in     = utf_ff;
      uidx_in    = uidx_ff;
      q_pop      = 1'b0;
      push       = 1'b0;
      push_byte  = 8'h00;
      hold       = 1'b0;
      hold_byte  = 8'h00;
      open_ref   = 1'b0;
      held_we    = 1'b0;
      done       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_word;
               state_in = ST_TAKE;
            end
         end
         ST_TAKE: begin
            if (!in_ref_ff) begin
               if (cur_ff.is_amp) begin
                  open_ref = 1'b1;
                  state_in = cur_ff.last ? ST_FLUSH : ST_END;
               end else if (can_push) begin
                  push      = 1'b1;
                  push_byte = cur_ff.data;
                  state_in  = ST_END;
               end
            end else if (cur_ff.is_semi) begin
               state_in = ST_FIN;
            end else if (count_ff < CW'(MAX_SPAN - 1)) begin
               hold      = 1'b1;
               hold_byte = cur_ff.data;
               state_in  = cur_ff.last ? ST_FLUSH : ST_END;
            end else if (can_push) begin
               // span exceeded: emit ampersand, rescan held bytes plus this one
               push      = 1'b1;
               push_byte = CH_AMP;
               held_we   = 1'b1;
               hold_byte = cur_ff.data;
               in_ref_in = 1'b0;
               count_in  = '0;
               rd_in     = '0;
               state_in  = ST_RESCAN;
            end
         end
         ST_FIN: begin
            if (can_push) begin
               in_ref_in = 1'b0;
               count_in  = '0;
               if (named_hit) begin
                  push      = 1'b1;
                  push_byte = named_char;
                  state_in  = ST_END;
               end else if ((count_ff > CW'(1)) && hash_ff) begin
                  utf_in   = utf8_enc(num_val);
                  uidx_in  = 2'd0;
                  state_in = num_ok ? ST_UTF : ST_END;
               end else begin
                  push       = 1'b1;
                  push_byte  = CH_AMP;
                  raw_len_in = count_ff;
                  semi_in    = 1'b1;
                  rd_in      = '0;
                  state_in   = ST_RAW;
               end
            end
         end
         ST_UTF: begin
            if (can_push) begin
               push      = 1'b1;
               push_byte = utf_ff.bytes[uidx_ff];
               uidx_in   = uidx_ff + 2'd1;
               if ({1'b0, uidx_ff} + 3'd1 == utf_ff.count) begin
                  state_in = ST_END;
               end
            end
         end
         ST_RAW: begin
            if (rd_ff != raw_len_ff) begin
               if (can_push) begin
                  push      = 1'b1;
                  push_byte = rd_byte;
                  rd_in     = rd_ff + CW'(1);
               end
            end else if (!semi_ff) begin
               state_in = ST_END;
            end else if (can_push) begin
               push      = 1'b1;
               push_byte = CH_SEMI;
               state_in  = ST_END;
            end
         end
         ST_RESCAN: begin
            if (in_ref_ff || rd_byte == CH_AMP || can_push) begin
               if (in_ref_ff) begin
                  hold      = 1'b1;
                  hold_byte = rd_byte;
               end else if (rd_byte == CH_AMP) begin
                  open_ref = 1'b1;
               end else begin
                  push      = 1'b1;
                  push_byte = rd_byte;
               end
               rd_in = rd_ff + CW'(1);
               if (rd_ff == CW'(MAX_SPAN - 1)) begin
                  state_in = cur_ff.last ? ST_FLUSH : ST_END;
               end
            end
         end
         ST_FLUSH: begin
            if (!in_ref_ff) begin
               state_in = ST_END;
            end else if (can_push) begin
               push       = 1'b1;
               push_byte  = CH_AMP;
               raw_len_in = count_ff;
               count_in   = '0;
               in_ref_in  = 1'b0;
               semi_in    = 1'b0;
               rd_in      = '0;
               state_in   = ST_RAW;
            end
         end
         ST_END: begin
            done = out_free || (!stg_valid_ff && !cur_ff.last);
            if (done) begin
               if (q_valid) begin
                  q_pop    = 1'b1;
                  cur_in   = q_word;
                  state_in = ST_TAKE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (open_ref) begin
         in_ref_in = 1'b1;
         count_in  = '0;
      end
      if (hold) begin
         held_we  = 1'b1;
         count_in = count_ff + CW'(1);
      end
   end

   // incremental match and digit tracking of the held body
   always_comb begin
      match_in   = match_ff;
      hash_in    = hash_ff;
      isx_in     = isx_ff;
      dec_ok_in  = dec_ok_ff;
      dec_val_in = dec_val_ff;
      hex_ok_in  = hex_ok_ff;
      hex_val_in = hex_val_ff;
      nm_word    = 32'h0;
      dg_dec     = digit_of(hold_byte, 1'b0);
      dg_hex     = digit_of(hold_byte, 1'b1);
      if (open_ref) begin
         match_in   = '1;
         hash_in    = 1'b0;
         isx_in     = 1'b0;
         dec_ok_in  = 1'b1;
         dec_val_in = '0;
         hex_ok_in  = 1'b1;
         hex_val_in = '0;
      end else if (hold) begin
         for (int k = 0; k < NUM_NAMES; k++) begin
            nm_word     = name_word(3'(k));
            match_in[k] = match_ff[k] && (count_ff < CW'(name_len(3'(k)))) &&
                          (hold_byte == nm_word[{count_ff[1:0], 3'b000} +: 8]);
         end
         if (count_ff == CW'(0)) begin
            hash_in = (hold_byte == CH_HASH);
         end else begin
            dec_ok_in  = dec_ok_ff && dg_dec[4];
            dec_val_in = acc_step(dec_val_ff, dg_dec[3:0], 1'b0);
         end
         if (count_ff == CW'(1)) begin
            isx_in = (hold_byte == CH_X_LO) || (hold_byte == CH_X_UP);
         end
         if (count_ff >= CW'(2)) begin
            hex_ok_in  = hex_ok_ff && dg_hex[4];
            hex_val_in = acc_step(hex_val_ff, dg_hex[3:0], 1'b1);
         end
      end
   end

   // staging byte and output register
   always_comb begin
      stg_valid_in = stg_valid_ff;
      stg_byte_in  = stg_byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_rl_in    = rsp_rl_ff;
      rsp_me_in    = rsp_me_ff;
      if (push) begin
         if (stg_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = stg_byte_ff;
            rsp_bv_in    = 1'b1;
            rsp_rl_in    = 1'b0;
            rsp_me_in    = 1'b0;
         end
         stg_valid_in = 1'b1;
         stg_byte_in  = push_byte;
      end else if (state_ff == ST_END && out_free) begin
         if (stg_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = stg_byte_ff;
            rsp_bv_in    = 1'b1;
            rsp_rl_in    = 1'b1;
            rsp_me_in    = cur_ff.last;
            stg_valid_in = 1'b0;
         end else if (cur_ff.last) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = 8'h00;
            rsp_bv_in    = 1'b0;
            rsp_rl_in    = 1'b1;
            rsp_me_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_ref_ff    <= 1'b0;
         count_ff     <= '0;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_ref_ff    <= in_ref_in;
         count_ff     <= count_in;
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rd_ff       <= rd_in;
      raw_len_ff  <= raw_len_in;
      semi_ff     <= semi_in;
      match_ff    <= match_in;
      hash_ff     <= hash_in;
      isx_ff      <= isx_in;
      dec_ok_ff   <= dec_ok_in;
      dec_val_ff  <= dec_val_in;
      hex_ok_ff   <= hex_ok_in;
      hex_val_ff  <= hex_val_in;
      utf_ff      <= utf_in;
      uidx_ff     <= uidx_in;
      stg_byte_ff <= stg_byte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_bv_ff   <= rsp_bv_in;
      rsp_rl_ff   <= rsp_rl_in;
      rsp_me_ff   <= rsp_me_in;
      if (held_we) begin
         held_ff[count_ff] <= hold_byte;
      end
   end

endmodule

>>> design/xml_entity_decoder.sv
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Streaming XML entity decoder: named and numeric references to UTF-8 bytes.
// ----------------------------------------------------------------------------
//   channel   dir   handshake              payload
//   req       in    req_valid / req_ready  req_in_byte, req_in_last
//   rsp       out   rsp_valid / rsp_ready  rsp_out_byte, rsp_byte_valid,
//                                          rsp_run_last, rsp_message_end
//
// a plain byte passes the take state, then the close-of-word state, in the back sequencer
// each emitted byte is a step of its own: a raw reference or span rescan walks the
// held bytes one per cycle unless the back stalls, up to MAX_SPAN bytes
// a two-word queue lets the input side keep taking words while the back stalls
// synchronous active-high reset; no clearing pass, held bytes need none
// a full output register with a waiting staging byte stalls the back
// ----------------------------------------------------------------------------
module xml_entity_decoder import xed_pkg::*; #(
   parameter int MAX_SPAN = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_message_end
);

   logic     q_valid;
   logic     q_pop;
   word_type q_word;

   xed_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_valid     (q_valid),
      .q_word      (q_word),
      .q_pop       (q_pop)
   );

   xed_back #(.MAX_SPAN(MAX_SPAN)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_word          (q_word),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end)
   );

   a_bare_marker_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_message_end && rsp_run_last)
      else $error("bare marker without message end");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_run_last)
      else $error("message end on a word that is not run last");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule

>>> test/xml_entity_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xml_entity_decoder_test
// Drives byte streams with named, numeric, raw and overlong references through
// the decoder, predicts the decoded words and checks every output field.
// ----------------------------------------------------------------------------
module xml_entity_decoder_test;
   import xed_pkg::*;

   localparam int SPAN = 12;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } in_word_type;

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       run_last;
      logic       message_end;
   } out_word_type;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [7:0] req_in_byte = 0;
   logic       req_in_last = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_run_last;
   logic       rsp_message_end;
   logic       req_ready_q = 0;

   in_word_type  pending_words[$];
   out_word_type decoded_words[$];
   out_word_type step_words[$];
   logic [7:0]   ent_held[SPAN];
   int           ent_count = 0;
   logic         ent_open = 0;
   int           errors = 0;
   int           idle_cycles = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           hold_off = 0;
   bit           stim_done = 0;

   xml_entity_decoder #(.MAX_SPAN(SPAN)) uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic void emit(input logic [7:0] b);
      out_word_type w;
      w.data = b;
      w.byte_valid = 1;
      w.run_last = 0;
      w.message_end = 0;
      step_words.insert(step_words.size(), w);
   endfunction

   function automatic bit body_matches(input string name);
      if (ent_count != name.len()) return 0;
      for (int i = 0; i < ent_count; i++)
         if (ent_held[i] != name[i]) return 0;
      return 1;
   endfunction

   function automatic void emit_utf8(input logic [20:0] v);
      if (v < 21'h80) begin
         emit(v[7:0]);
      end else if (v < 21'h800) begin
         emit({3'b110, v[10:6]});
         emit({2'b10, v[5:0]});
      end else if (v < 21'h10000) begin
         emit({4'b1110, v[15:12]});
         emit({2'b10, v[11:6]});
         emit({2'b10, v[5:0]});
      end else begin
         emit({5'b11110, v[20:18]});
         emit({2'b10, v[17:12]});
         emit({2'b10, v[11:6]});
         emit({2'b10, v[5:0]});
      end
   endfunction

   function automatic void close_entity();
      bit hex;
      bit ok;
      int base;
      int d;
      longint v;
      logic [7:0] c;
      if (body_matches("amp")) emit(CH_AMP);
      else if (body_matches("lt")) emit(8'h3C);
      else if (body_matches("gt")) emit(8'h3E);
      else if (body_matches("quot")) emit(8'h22);
      else if (body_matches("apos")) emit(8'h27);
      else if (ent_count > 1 && ent_held[0] == CH_HASH) begin
         hex = ent_count > 2 && (ent_held[1] == CH_X_LO || ent_held[1] == CH_X_UP);
         base = hex ? 16 : 10;
         v = 0;
         ok = 1;
         for (int i = hex ? 2 : 1; i < ent_count; i++) begin
            c = ent_held[i];
            if (c >= "0" && c <= "9") d = c - "0";
            else if (c >= "a" && c <= "f") d = c - "a" + 10;
            else if (c >= "A" && c <= "F") d = c - "A" + 10;
            else d = 99;
            if (d >= base) begin
               ok = 0;
               break;
            end
            v = v * base + d;
            if (v > CODE_MAX) v = CODE_MAX + 1;
         end
         if (ok && v > 0 && v <= CODE_MAX) emit_utf8(v[20:0]);
      end else begin
         emit(CH_AMP);
         for (int i = 0; i < ent_count; i++) emit(ent_held[i]);
         emit(CH_SEMI);
      end
      ent_open = 0;
      ent_count = 0;
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      logic [7:0] seq[$];
      if (!ent_open) begin
         if (b == CH_AMP) begin
            ent_open = 1;
            ent_count = 0;
         end else begin
            emit(b);
         end
      end else if (b == CH_SEMI) begin
         close_entity();
      end else if (ent_count + 1 < SPAN) begin
         ent_held[ent_count++] = b;
      end else begin
         for (int i = 0; i < ent_count; i++) seq.insert(seq.size(), ent_held[i]);
         seq.insert(seq.size(), b);
         ent_open = 0;
         ent_count = 0;
         emit(CH_AMP);
         foreach (seq[i]) begin
            if (ent_open) begin
               if (ent_count < SPAN) ent_held[ent_count++] = seq[i];
            end else if (seq[i] == CH_AMP) begin
               ent_open = 1;
               ent_count = 0;
            end else begin
               emit(seq[i]);
            end
         end
      end
   endfunction

   function automatic void predict_word(input in_word_type w);
      out_word_type e;
      step_words.delete();
      decode_byte(w.data);
      if (w.last) begin
         if (ent_open) begin
            emit(CH_AMP);
            for (int i = 0; i < ent_count; i++) emit(ent_held[i]);
         end
         ent_open = 0;
         ent_count = 0;
         if (step_words.size() == 0) begin
            e = '0;
            step_words.insert(step_words.size(), e);
         end
         step_words[$].message_end = 1;
      end
      if (step_words.size() > 0) step_words[$].run_last = 1;
      foreach (step_words[i]) decoded_words.insert(decoded_words.size(), step_words[i]);
   endfunction

   task automatic add_text(input string s, input bit last_at_end);
      in_word_type w;
      for (int i = 0; i < s.len(); i++) begin
         w.data = s[i];
         w.last = last_at_end && i == s.len() - 1;
         pending_words.insert(pending_words.size(), w);
      end
   endtask

   function automatic string rand_entity();
      string s;
      int n;
      case ($urandom_range(0, 9))
         0: s = "&amp;";
         1: s = "&lt;";
         2: s = "&gt;";
         3: s = "&quot;";
         4: s = "&apos;";
         5: s = $sformatf("&#%0d;", $urandom_range(0, 1200000));
         6: s = $sformatf(($urandom_range(0, 1) ? "&#x%0h;" : "&#X%0H;"),
                          $urandom_range(0, 24'h120000));
         7: s = "&#;";
         default: begin
            s = "&";
            n = $urandom_range(0, 13);
            for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(0, 255)))};
            if ($urandom_range(0, 1)) s = {s, ";"};
         end
      endcase
      return s;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_q) begin
            predict_word(pending_words.pop_front());
         end
         if (!(req_valid && !req_ready_q)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 0;
            end else if (pending_words.size() > 0) begin
               req_valid <= 1;
               req_in_byte <= pending_words[0].data;
               req_in_last <= pending_words[0].last;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
               end
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      out_word_type e;
      req_ready_q <= req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_words.size() == 0) begin
            $display("%0t: unexpected word byte=%h", $time, rsp_out_byte);
            errors++;
         end else begin
            e = decoded_words.pop_front();
            if ({rsp_out_byte, rsp_byte_valid, rsp_run_last, rsp_message_end} !== e) begin
               $display("%0t: mismatch expected %h/%b/%b/%b actual %h/%b/%b/%b", $time,
                        e.data, e.byte_valid, e.run_last, e.message_end, rsp_out_byte,
                        rsp_byte_valid, rsp_run_last, rsp_message_end);
               errors++;
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   // receiver stall pattern with one long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_ready <= 0;
      end else if (!reset) begin
         rsp_ready <= ($urandom_range(0, 7) < 5) || stim_done;
      end
   end

   initial begin
      string s;
      int d;
      in_word_type iw;
      repeat (3) @(posedge clock);
      reset <= 0;
      add_text("a&amp;&lt;&gt;&quot;&apos;", 0);
      add_text("&#65;&#x3A9;&#X20AC;&#x1F600;&#1114111;&#1114112;", 0);
      add_text("&#0;&#x;&#12a;&foo;&abcdefghijklm", 0);
      iw = '{8'hFF, 1'b0};
      pending_words.insert(pending_words.size(), iw);
      iw = '{8'h00, 1'b0};
      pending_words.insert(pending_words.size(), iw);
      add_text("&ab", 1);
      add_text("&&", 1);
      hold_off = 120;
      while (pending_words.size() < 270) begin
         d = $urandom_range(0, 9);
         if (d < 6) s = rand_entity();
         else s = string'(byte'($urandom_range(0, 255)));
         add_text(s, $urandom_range(0, 12) == 0);
      end
      add_text("x", 1);
      wait (pending_words.size() == 0 || idle_cycles > STALL_LIMIT);
      stim_done = 1;
      wait (decoded_words.size() == 0 || idle_cycles > STALL_LIMIT);
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_words.size() == 0 && decoded_words.size() == 0 &&
          idle_cycles <= STALL_LIMIT)
         $display("xml_entity_decoder test passed");
      else
         $display("xml_entity_decoder test failed");
      $finish;
   end
endmodule
